### rtl/ebs_pkg.sv
// Shared types, constants and servo command arithmetic for the eyelid blink sequencer.
package ebs_pkg;

  localparam int BLINK_PERIOD_DEF   = 100;
  localparam int SETTLE_DIVISOR_DEF = 200;

  localparam int MAX_CMDS  = 3;
  localparam int CMD_CNT_W = 2;

  localparam logic [15:0] LID_CLOSED_POS = 16'd16384;
  // |old - new| * 100 > 65536 holds exactly when |old - new| > 655
  localparam logic [15:0] CHANGE_LIMIT = 16'd655;
  localparam logic [15:0] OPEN_BASE    = 16'd55706;
  // floor(2^20 / 25)
  localparam logic [15:0] OPEN_RECIP   = 16'd41943;
  localparam logic [19:0] OPEN_DIV     = 20'd25;
  localparam logic [16:0] SPEED_TOP    = 17'd32768;

  typedef struct packed {
    logic        kind;
    logic [15:0] boredom;
    logic [15:0] sleepiness_value;
    logic        servo_moving;
  } item_t;

  typedef struct packed {
    logic        reopen;
    logic [15:0] reopen_sleep;
    logic        blink;
    logic [15:0] old_sleep;
    logic        change;
    logic [15:0] new_sleep;
  } stage_t;

  typedef struct packed {
    logic        speed_valid;
    logic [15:0] servo_speed;
    logic [15:0] target_position;
  } cmd_t;

  typedef struct packed {
    cmd_t [MAX_CMDS-1:0]  cmds;
    logic [CMD_CNT_W-1:0] count;
  } cmd_set_t;

  // 2 - 1.5*s in Q2.14, product rounded half up
  function automatic logic [15:0] speed_of(input logic [15:0] s);
    logic [17:0] t;
    t = {2'b00, s} + {1'b0, s, 1'b0} + 18'd4;
    return 16'(SPEED_TOP - {2'b00, t[17:3]});
  endfunction

  // 0.85 - 0.48*s rounded, computed as 55706 - floor((12*s + 22) / 25)
  function automatic logic [15:0] open_pos_of(input logic [15:0] s);
    logic [19:0] z;
    logic [35:0] prod;
    logic [15:0] q0;
    logic [19:0] r;
    logic [15:0] q;
    z    = {1'b0, s, 3'b000} + {2'b00, s, 2'b00} + 20'd22;
    prod = {16'd0, z} * {20'd0, OPEN_RECIP};
    q0   = prod[35:20];
    // estimate is low by at most one
    r    = z - ({q0, 4'b0000} + {1'b0, q0, 3'b000} + {4'b0000, q0});
    q    = q0 + 16'(r >= OPEN_DIV);
    return OPEN_BASE - q;
  endfunction

endpackage

### rtl/ebs_update.sv
// Sequencer state: blink counter, queued reopen and sleepiness tracking, one item per cycle while out_ready_i is high.
module ebs_update #(
  parameter int BLINK_PERIOD   = ebs_pkg::BLINK_PERIOD_DEF,
  parameter int SETTLE_DIVISOR = ebs_pkg::SETTLE_DIVISOR_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  ebs_pkg::item_t   item_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output ebs_pkg::stage_t  stage_o
);

  localparam int DivShift = 16 + $clog2(SETTLE_DIVISOR);
  localparam int DivMult  = ((1 << DivShift) + SETTLE_DIVISOR - 1) / SETTLE_DIVISOR;

  logic [15:0]     sleep_q, sleep_d;
  logic [6:0]      blink_q, blink_d;
  logic            pend_q, pend_d;
  logic [15:0]     reopen_q, reopen_d;
  logic            valid_q, valid_d;
  ebs_pkg::stage_t stage_q, stage_d;

  logic        adv;
  logic [7:0]  cnt;
  logic [15:0] gap;
  logic [33:0] prod;
  logic [15:0] quot;
  logic [15:0] diff;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign adv         = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign stage_o     = stage_q;

  always_comb begin
    sleep_d  = sleep_q;
    blink_d  = blink_q;
    pend_d   = pend_q;
    reopen_d = reopen_q;
    stage_d  = '0;
    cnt      = {1'b0, blink_q} + 8'd1;
    gap      = item_i.boredom - sleep_q;
    prod     = {18'd0, gap} * 34'(DivMult);
    quot     = 16'(prod >> DivShift);

    stage_d.old_sleep    = sleep_q;
    stage_d.reopen_sleep = reopen_q;
    if (item_i.kind) begin
      stage_d.new_sleep = item_i.sleepiness_value;
    end else begin
      stage_d.reopen = !item_i.servo_moving && pend_q;
      if (stage_d.reopen) begin
        pend_d = 1'b0;
      end
      if (cnt > 8'(BLINK_PERIOD)) begin
        stage_d.blink = 1'b1;
        blink_d       = '0;
        reopen_d      = sleep_q;
        pend_d        = 1'b1;
      end else begin
        blink_d = cnt[6:0];
      end
      // drop at once toward lower boredom, otherwise creep up
      if (item_i.boredom < sleep_q) begin
        stage_d.new_sleep = item_i.boredom;
      end else begin
        stage_d.new_sleep = sleep_q + quot;
      end
    end
    diff = (stage_d.new_sleep > sleep_q) ? stage_d.new_sleep - sleep_q
                                         : sleep_q - stage_d.new_sleep;
    stage_d.change = diff > ebs_pkg::CHANGE_LIMIT;
    sleep_d        = stage_d.new_sleep;
    valid_d        = adv || (valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sleep_q  <= '0;
      blink_q  <= '0;
      pend_q   <= 1'b0;
      reopen_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (adv) begin
        sleep_q  <= sleep_d;
        blink_q  <= blink_d;
        pend_q   <= pend_d;
        reopen_q <= reopen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      stage_q <= stage_d;
    end
  end

endmodule

### rtl/ebs_format.sv
// Builds the servo commands of one item and packs them in issue order.
module ebs_format (
  input  ebs_pkg::stage_t   stage_i,
  output ebs_pkg::cmd_set_t set_o
);

  ebs_pkg::cmd_t [ebs_pkg::MAX_CMDS-1:0] cand;
  logic [ebs_pkg::MAX_CMDS-1:0]          flag;

  always_comb begin
    cand[0].speed_valid     = 1'b0;
    cand[0].servo_speed     = '0;
    cand[0].target_position = ebs_pkg::open_pos_of(stage_i.reopen_sleep);
    cand[1].speed_valid     = 1'b1;
    cand[1].servo_speed     = ebs_pkg::speed_of(stage_i.old_sleep);
    cand[1].target_position = ebs_pkg::LID_CLOSED_POS;
    cand[2].speed_valid     = 1'b1;
    cand[2].servo_speed     = ebs_pkg::speed_of(stage_i.new_sleep);
    cand[2].target_position = ebs_pkg::open_pos_of(stage_i.new_sleep);
    flag = {stage_i.change, stage_i.blink, stage_i.reopen};
  end

  always_comb begin
    logic [ebs_pkg::CMD_CNT_W-1:0] cnt;
    cnt   = '0;
    set_o = '0;
    for (int i = 0; i < ebs_pkg::MAX_CMDS; i++) begin
      if (flag[i]) begin
        set_o.cmds[cnt] = cand[i];
        cnt             = cnt + 1'b1;
      end
    end
    set_o.count = ebs_pkg::CMD_CNT_W'($countones(flag));
  end

endmodule

### rtl/ebs_out_buffer.sv
// Result register: holds up to three commands and issues one per transfer.
module ebs_out_buffer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_valid_i,
  input  ebs_pkg::cmd_set_t set_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ebs_pkg::cmd_t     cmd_o,
  output logic              last_o
);

  ebs_pkg::cmd_t [ebs_pkg::MAX_CMDS-1:0] ent_q, ent_d;
  logic [ebs_pkg::CMD_CNT_W-1:0]         count_q, count_d;
  logic                                  pop, load;

  assign out_valid_o = count_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign free_o      = (count_q == '0) || (count_q == 2'd1 && pop);
  assign load        = load_valid_i && free_o;
  assign cmd_o       = ent_q[0];
  assign last_o      = count_q == 2'd1;

  always_comb begin
    ent_d   = ent_q;
    count_d = count_q;
    if (load) begin
      ent_d   = set_i.cmds;
      count_d = set_i.count;
    end else if (pop) begin
      // advance the queue toward the port
      for (int i = 0; i < ebs_pkg::MAX_CMDS - 1; i++) begin
        ent_d[i] = ent_q[i+1];
      end
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

### rtl/eyelid_blink_sequencer.sv
// Eyelid blink sequencer top level: input register, state update, command build, result buffer.
// Path: the first command of an item passes the input register, the state update register and the result buffer.
// Output: the single output port drains the command buffer one command per transfer, at most 3 commands
//   per item; the next item's commands load into an empty buffer or as the last command leaves.
// Reset: rst_ni low clears sleepiness, blink count, queued reopen and all valid flags at once.
module eyelid_blink_sequencer #(
  parameter int BLINK_PERIOD   = ebs_pkg::BLINK_PERIOD_DEF,
  parameter int SETTLE_DIVISOR = ebs_pkg::SETTLE_DIVISOR_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // boredom[15:0], sleepiness_value[31:16], servo_moving[32]
  input  logic        s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // servo_speed[15:0], target_position[31:16]
  output logic        m_axis_tuser,  // speed_valid
  output logic        m_axis_tlast   // last
);

  ebs_pkg::item_t    item_q, item_d;
  logic              in_valid_q, in_valid_d;
  logic              take, upd_ready, upd_valid, buf_free;
  ebs_pkg::stage_t   stage;
  ebs_pkg::cmd_set_t set;
  ebs_pkg::cmd_t     cmd;

  assign s_axis_tready = !in_valid_q || upd_ready;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_d.kind             = s_axis_tuser;
    item_d.boredom          = s_axis_tdata[15:0];
    item_d.sleepiness_value = s_axis_tdata[31:16];
    item_d.servo_moving     = s_axis_tdata[32];
    in_valid_d              = take || (in_valid_q && !upd_ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  ebs_update #(
    .BLINK_PERIOD   (BLINK_PERIOD),
    .SETTLE_DIVISOR (SETTLE_DIVISOR)
  ) u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .item_i      (item_q),
    .in_ready_o  (upd_ready),
    .out_ready_i (buf_free),
    .out_valid_o (upd_valid),
    .stage_o     (stage)
  );

  ebs_format u_format (
    .stage_i (stage),
    .set_o   (set)
  );

  ebs_out_buffer u_out_buffer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (upd_valid),
    .set_i        (set),
    .free_o       (buf_free),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .cmd_o        (cmd),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {cmd.target_position, cmd.servo_speed};
  assign m_axis_tuser = cmd.speed_valid;

endmodule

### rtl/ebs_checker.sv
// Port-level checks for the eyelid blink sequencer, bound to the top level.
module ebs_port_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // hold a stalled command
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output command changed while stalled");

  a_reopen_no_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:0] == 16'd0)
    else $error("queued reopen carries a speed");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[15:0] >= 16'd8192 && m_axis_tdata[15:0] <= 16'd32768)
    else $error("servo speed out of range");

  a_reopen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[31:16] >= 16'd24249 && m_axis_tdata[31:16] <= 16'd55706)
    else $error("queued reopen target outside the open range");

endmodule

bind eyelid_blink_sequencer ebs_port_props u_ebs_port_props (.*);
